// ===== rtl/core/tms_pkg.sv =====
// Package with the sequencer state type shared by the scheduling block.
`default_nettype none

package tms_pkg;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CLEAR  = 8'b0000_0010,
        ST_RD_B   = 8'b0000_0100,
        ST_RD     = 8'b0000_1000,
        ST_WR     = 8'b0001_0000,
        ST_SC_RD  = 8'b0010_0000,
        ST_SC_CHK = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/two_machine_schedule_makespan.sv =====
// Two-machine scheduling block: reachable-load bitmap and minimum makespan search.
// Usage: a job transaction (time_a, time_b, last_job) is taken when job_valid is high
// and job_stall is low. Each job rewrites the (load A, load B) bitmap in a memory of
// (MAX_LOAD+1) rows of ROW_WORDS words, from the top row down, through a single
// shift-and-OR unit: each row opens with a read state (ST_RD_B), then each word takes
// a read state (ST_RD) and a write state (ST_WR). job_stall is high throughout a job.
// A job with last_job set is followed by a scan of all 1024 words, each one read
// (ST_SC_RD) and then checked (ST_SC_CHK), after which one result transaction
// (makespan, overflow) is offered on res_valid. The block then clears the memory back
// to the origin pair, one word per cycle, before taking the next job.
// After reset the same clearing pass runs first with job_stall high. The result is
// held in an output register; if the receiver stalls, it waits there while the clearing
// pass runs, and a later result is not produced over it until it has been taken.
`default_nettype none

module two_machine_schedule_makespan #(
    parameter int MAX_LOAD  = 255,
    parameter int WORD_BITS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    output logic            job_stall,
    input  wire logic [5:0] time_a,
    input  wire logic [5:0] time_b,
    input  wire logic       last_job,
    output logic            res_valid,
    input  wire logic       res_stall,
    output logic [7:0]      makespan,
    output logic            overflow
);
    import tms_pkg::*;

    localparam int ROWS        = MAX_LOAD + 1;
    localparam int ROW_WORDS   = (MAX_LOAD + WORD_BITS) / WORD_BITS;
    localparam int TOTAL_WORDS = ROWS * ROW_WORDS;
    localparam int RW          = $clog2(ROWS);
    localparam int WW          = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int AW          = $clog2(TOTAL_WORDS);
    localparam int CW          = $clog2(MAX_LOAD + WORD_BITS + 1);

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [WW-1:0] w);
        addr_of = AW'(AW'(r) * AW'(ROW_WORDS) + AW'(w));
    endfunction

    function automatic logic [CW-1:0] col_of(input logic [WW-1:0] w);
        col_of = CW'(CW'(w) * CW'(WORD_BITS));
    endfunction

    state_t state_reg, state_next;

    logic [5:0]    ta_reg, r_reg;
    logic [2:0]    q_reg;
    logic          last_reg;
    logic [RW-1:0] row_reg;
    logic [WW-1:0] w_reg;
    logic [AW-1:0] clr_reg;
    logic          a_ok_reg, b_ok_reg, c_ok_reg;
    logic [WORD_BITS-1:0] b_word_reg;
    logic [RW-1:0] best_reg;
    logic          found_reg;
    logic          res_valid_reg;
    logic [7:0]    makespan_reg;
    logic          overflow_reg;

    logic [WORD_BITS-1:0] mem [TOTAL_WORDS];
    logic [WORD_BITS-1:0] rd0_reg, rd1_reg;
    logic [AW-1:0] rd0_addr, rd1_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic          wr_en;

    // Split of time_b into whole words and a bit shift.
    logic [5:0]    split_r;
    logic [2:0]    split_q;
    always_comb
    begin
        split_r = time_b;
        split_q = 3'd0;
        for (int k = 0; k < 8; k++)
        begin
            if ({1'b0, split_r} >= 7'(WORD_BITS))
            begin
                split_r = 6'({1'b0, split_r} - 7'(WORD_BITS));
                split_q = split_q + 3'd1;
            end
        end
    end

    logic [RW+5:0] a_diff;
    logic          a_ok;
    logic [WW+3:0] b_diff, c_diff;
    logic          b_ok, c_ok;
    assign a_diff = (RW+6)'(row_reg) - (RW+6)'(ta_reg);
    assign a_ok   = ~a_diff[RW+5];
    assign b_diff = (WW+4)'(w_reg) - (WW+4)'(q_reg);
    assign b_ok   = ~b_diff[WW+3];
    assign c_diff = b_diff - (WW+4)'(1);
    assign c_ok   = ~c_diff[WW+3];

    // Shift-and-OR unit producing one new bitmap word.
    logic [WORD_BITS-1:0]   a_word, c_word, new_word, col_mask;
    logic [2*WORD_BITS-1:0] cat_sh;
    logic [CW-1:0]          wcol;
    always_comb
    begin
        a_word = a_ok_reg ? rd0_reg : '0;
        c_word = c_ok_reg ? rd1_reg : '0;
        cat_sh = {b_word_reg, c_word} << r_reg;
        wcol   = col_of(w_reg);
        for (int k = 0; k < WORD_BITS; k++)
        begin
            col_mask[k] = (wcol + CW'(k)) <= CW'(MAX_LOAD);
        end
        new_word = (a_word | cat_sh[2*WORD_BITS-1:WORD_BITS]) & col_mask;
    end

    // Scan of one stored word for the least max(load A, load B).
    logic          sc_hit;
    logic [RW-1:0] sc_cand;
    logic [CW-1:0] low_col;
    logic          low_any;
    always_comb
    begin
        low_any = 1'b0;
        low_col = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (rd0_reg[k])
            begin
                low_col = wcol + CW'(k);
            end
            if (rd0_reg[k] && ((wcol + CW'(k)) <= CW'(row_reg)))
            begin
                low_any = 1'b1;
            end
        end
        sc_hit  = (rd0_reg != '0);
        sc_cand = low_any ? row_reg : RW'(low_col);
    end

    logic accept;
    assign accept = job_valid && !job_stall;

    always_comb
    begin
        state_next = state_reg;
        rd0_addr   = addr_of(RW'(a_diff), w_reg);
        rd1_addr   = addr_of(row_reg, WW'(c_diff));
        wr_addr    = addr_of(row_reg, w_reg);
        wr_data    = new_word;
        wr_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD_B;
                end
            end
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = (clr_reg == '0) ? WORD_BITS'(1) : '0;
                if (clr_reg == AW'(TOTAL_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_B:
            begin
                rd1_addr   = addr_of(row_reg, WW'(b_diff));
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                wr_en = 1'b1;
                if (w_reg != '0)
                begin
                    state_next = ST_RD;
                end
                else if (row_reg != '0)
                begin
                    state_next = ST_RD_B;
                end
                else
                begin
                    state_next = last_reg ? ST_SC_RD : ST_IDLE;
                end
            end
            ST_SC_RD:
            begin
                rd0_addr   = addr_of(row_reg, w_reg);
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK:
            begin
                if ((row_reg == RW'(ROWS - 1)) && (w_reg == WW'(ROW_WORDS - 1)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd0_reg <= mem[rd0_addr];
        rd1_reg <= mem[rd1_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            row_reg       <= '0;
            w_reg         <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ta_reg   <= time_a;
                        r_reg    <= split_r;
                        q_reg    <= split_q;
                        last_reg <= last_job;
                        row_reg  <= RW'(ROWS - 1);
                        w_reg    <= WW'(ROW_WORDS - 1);
                    end
                end
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                ST_RD_B:
                begin
                    b_ok_reg <= b_ok;
                end
                ST_RD:
                begin
                    a_ok_reg <= a_ok;
                    c_ok_reg <= c_ok;
                    // The word read in the previous cycle is the upper half of the shift window; its
                    // valid flag comes from ST_RD_B at the start of a row and later from the last write.
                    if (b_ok_reg)
                    begin
                        b_word_reg <= rd1_reg;
                    end
                    else
                    begin
                        b_word_reg <= '0;
                    end
                    b_ok_reg <= 1'b1;
                end
                ST_WR:
                begin
                    b_word_reg <= c_word;
                    b_ok_reg   <= c_ok_reg;
                    if (w_reg != '0)
                    begin
                        w_reg <= w_reg - WW'(1);
                    end
                    else if (row_reg != '0)
                    begin
                        row_reg <= row_reg - RW'(1);
                        w_reg   <= WW'(ROW_WORDS - 1);
                    end
                    else
                    begin
                        found_reg <= 1'b0;
                        best_reg  <= '0;
                    end
                end
                ST_SC_RD:
                begin
                end
                ST_SC_CHK:
                begin
                    if (sc_hit && (!found_reg || (sc_cand < best_reg)))
                    begin
                        best_reg  <= sc_cand;
                        found_reg <= 1'b1;
                    end
                    if (w_reg == WW'(ROW_WORDS - 1))
                    begin
                        w_reg   <= '0;
                        row_reg <= row_reg + RW'(1);
                    end
                    else
                    begin
                        w_reg <= w_reg + WW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        makespan_reg  <= found_reg ? 8'((RW+8)'(best_reg)) : 8'd0;
                        overflow_reg  <= !found_reg;
                        clr_reg       <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign job_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign makespan  = makespan_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire

// ===== tb/tb_two_machine_schedule_makespan.sv =====
// Testbench for the two-machine scheduling block, with a scoreboard that predicts each makespan.
`default_nettype none

module tb_two_machine_schedule_makespan;

    localparam int LOADS = 256;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_JOBS = 560;

    typedef struct {
        logic [7:0] makespan;
        logic       overflow;
    } result_t;

    class MakespanBoard;
        bit [LOADS-1:0] load_map [LOADS];
        result_t        pending [$];
        int             errors;

        function new();
            clear_map();
            errors = 0;
        endfunction

        function void clear_map();
            foreach (load_map[i])
                load_map[i] = '0;
            load_map[0][0] = 1'b1;
        endfunction

        // Each job unions the set moved along load A with the set moved along load B.
        function void note_job(logic [5:0] ta, logic [5:0] tb, logic last);
            bit [LOADS-1:0] prev [LOADS];
            result_t        res;
            int             best;
            int             j;
            prev = load_map;
            for (int i = 0; i < LOADS; i++)
            begin
                load_map[i] = prev[i] << tb;
                if (i >= ta)
                    load_map[i] |= prev[i - ta];
            end
            if (!last)
                return;
            best = 1 << 20;
            // The lowest set load B in a row gives that row's smallest maximum.
            for (int i = 0; i < LOADS; i++)
            begin
                if (load_map[i] != '0)
                begin
                    j = 0;
                    while (!load_map[i][j])
                        j++;
                    if ((i > j ? i : j) < best)
                        best = i > j ? i : j;
                end
            end
            res.overflow = (best == (1 << 20));
            res.makespan = res.overflow ? 8'd0 : best[7:0];
            pending.push_back(res);
            clear_map();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [7:0] ms, logic ovf);
            result_t exp_res;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result makespan=%0d overflow=%0b", ms, ovf));
                return;
            end
            exp_res = pending.pop_front();
            if (ms !== exp_res.makespan)
                report($sformatf("makespan %0d, expected %0d", ms, exp_res.makespan));
            if (ovf !== exp_res.overflow)
                report($sformatf("overflow %0b, expected %0b", ovf, exp_res.overflow));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       job_valid;
    logic       job_stall;
    logic [5:0] time_a;
    logic [5:0] time_b;
    logic       last_job;
    logic       res_valid;
    logic       res_stall;
    logic [7:0] makespan;
    logic       overflow;

    MakespanBoard board;
    int           stall_pct;
    bit           quiet;
    int           idle_cycles;

    two_machine_schedule_makespan uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_stall (job_stall),
        .time_a    (time_a),
        .time_b    (time_b),
        .last_job  (last_job),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .makespan  (makespan),
        .overflow  (overflow)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Results are taken and the stall redrawn on every edge; the watchdog shares the block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                board.check_result(makespan, overflow);
            if ((res_valid && !res_stall) || (job_valid && !job_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            if (quiet)
                res_stall <= 1'b0;
            else if ($urandom_range(0, 99) < stall_pct)
                res_stall <= 1'b1;
            else
                res_stall <= 1'b0;
        end
    end

    task send_job(logic [5:0] ta, logic [5:0] tb, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            job_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_valid <= 1'b1;
        time_a    <= ta;
        time_b    <= tb;
        last_job  <= last;
        do
            @(posedge clk);
        while (!(job_valid && !job_stall));
        board.note_job(ta, tb, last);
    endtask

    task send_set(int count, int top);
        for (int k = 0; k < count; k++)
            send_job(6'($urandom_range(0, top)), 6'($urandom_range(0, top)), k == count - 1);
    endtask

    task wait_drained();
        job_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int count;
        board       = new();
        rst_n       = 1'b0;
        job_valid   = 1'b0;
        time_a      = '0;
        time_b      = '0;
        last_job    = 1'b0;
        res_stall   = 1'b0;
        stall_pct   = 20;
        quiet       = 1'b0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero times, extreme times, a set with no last mark until late,
        // and a set long enough that every schedule exceeds the load bound.
        send_job(6'd0, 6'd0, 1'b1);
        send_job(6'd63, 6'd63, 1'b1);
        send_job(6'd0, 6'd63, 1'b0);
        send_job(6'd63, 6'd0, 1'b1);
        send_job(6'd5, 6'd9, 1'b0);
        send_job(6'd7, 6'd3, 1'b0);
        send_job(6'd0, 6'd12, 1'b0);
        send_job(6'd42, 6'd21, 1'b1);
        repeat (9) send_job(6'd63, 6'd63, 1'b0);
        send_job(6'd63, 6'd63, 1'b1);
        send_job(6'd1, 6'd62, 1'b1);

        // The sender holds off here until every result has come back.
        wait_drained();

        sent = 0;
        while (sent < RANDOM_JOBS)
        begin
            quiet     = ($urandom_range(0, 9) == 0);
            stall_pct = $urandom_range(0, 3) * 20;
            if ($urandom_range(0, 9) == 0)
            begin
                count = $urandom_range(9, 12);
                send_set(count, 63);
            end
            else
            begin
                count = $urandom_range(1, 6);
                send_set(count, $urandom_range(0, 1) ? 63 : 15);
            end
            sent += count;
        end

        quiet = 1'b0;
        stall_pct = 20;
        wait_drained();
        repeat (5000) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/tms_pkg.sv
rtl/core/two_machine_schedule_makespan.sv
tb/tb_two_machine_schedule_makespan.sv
